### hdl/dltq_pkg.sv
`default_nettype none

package dltq_pkg;

  // Field widths of one pending timeout.
  localparam int DELTA_W = 16;
  localparam int HANDLE_W = 8;
  localparam int ARG_W = 32;

  // At most this many expired entries are reported for one tick.
  localparam int MAX_RESULTS = 16;

  // Input item kinds.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_EXPIRED = 2'd0;
  localparam logic [1:0] STATUS_ACCEPT = 2'd1;
  localparam logic [1:0] STATUS_REJECT = 2'd2;

  // One input item.
  typedef struct packed {
    logic                kind;
    logic [DELTA_W-1:0]  delay;
    logic [HANDLE_W-1:0] handle;
    logic [ARG_W-1:0]    argument;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] expired_handle;
    logic [ARG_W-1:0]    expired_argument;
    logic                last;
  } res_item_t;

  // One stored list entry.
  typedef struct packed {
    logic [DELTA_W-1:0]  delta;
    logic [HANDLE_W-1:0] handle;
    logic [ARG_W-1:0]    argument;
  } entry_t;

  // Flags and difference from the shared subtractor.
  typedef struct packed {
    logic [DELTA_W-1:0] diff;
    logic               borrow;
    logic               zero;
  } alu_res_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_WALK,
    ST_INS_SHIFT,
    ST_TICK_SCAN,
    ST_TICK_FLUSH,
    ST_TICK_COMPACT
  } state_e;

endpackage

`default_nettype wire

### hdl/delta_list_timer_queue.sv
`default_nettype none

// Timer queue kept as a delta list in a single-port-write, single-port-read
// memory, walked one entry per cycle by a small sequencer around one shared
// 16-bit subtractor. An item is taken when start is high and busy is low.
// An insert walks the list and then shifts the displaced entries back;
// an insert into a full list is answered at once without going busy. A tick
// on an empty list is taken without going busy; otherwise it scans up to the
// first positive delta or the end of the expired run, one entry per cycle,
// then passes through a flush state and, when entries expired and some
// survive, moves the surviving entries to the front.
// Results appear on res_o for exactly one cycle, marked by res_valid_o, and
// must be taken then: there is no back-pressure. The last result caused by
// an item carries last set; a tick that expires nothing gives no result.
module delta_list_timer_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire dltq_pkg::in_item_t  cmd_i,
  output logic                     res_valid_o,
  output dltq_pkg::res_item_t      res_o
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int MaxEmit = (QUEUE_DEPTH < dltq_pkg::MAX_RESULTS) ?
                           QUEUE_DEPTH : dltq_pkg::MAX_RESULTS;

  dltq_pkg::state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] i_next;
  logic [dltq_pkg::DELTA_W-1:0] t_q, t_d;
  logic [dltq_pkg::HANDLE_W-1:0] new_handle_q, new_handle_d;
  logic [dltq_pkg::ARG_W-1:0] new_arg_q, new_arg_d;
  dltq_pkg::entry_t carry_q, carry_d;
  logic fix_q, fix_d;
  logic dec_done_q, dec_done_d;
  logic emit_q, emit_d;
  logic pend_valid_q, pend_valid_d;
  logic [dltq_pkg::HANDLE_W-1:0] pend_handle_q, pend_handle_d;
  logic [dltq_pkg::ARG_W-1:0] pend_arg_q, pend_arg_d;
  logic res_valid_q, res_valid_d;
  dltq_pkg::res_item_t res_q, res_d;

  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  dltq_pkg::entry_t mem_wdata;
  dltq_pkg::entry_t mem_rdata;

  logic [dltq_pkg::DELTA_W-1:0] alu_a;
  logic [dltq_pkg::DELTA_W-1:0] alu_b;
  dltq_pkg::alu_res_t alu_res;

  logic dec_now;
  logic emit_ok;

  dltq_mem #(
    .DEPTH(QUEUE_DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  dltq_alu u_alu (
    .a_i  (alu_a),
    .b_i  (alu_b),
    .res_o(alu_res)
  );

  assign i_next = i_q + CW'(1);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dltq_pkg::ST_IDLE;
      count_q <= '0;
      res_valid_q <= 1'b0;
      pend_valid_q <= 1'b0;
      emit_q <= 1'b0;
      dec_done_q <= 1'b0;
      fix_q <= 1'b0;
      i_q <= '0;
      n_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      res_valid_q <= res_valid_d;
      pend_valid_q <= pend_valid_d;
      emit_q <= emit_d;
      dec_done_q <= dec_done_d;
      fix_q <= fix_d;
      i_q <= i_d;
      n_q <= n_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    t_q <= t_d;
    new_handle_q <= new_handle_d;
    new_arg_q <= new_arg_d;
    carry_q <= carry_d;
    pend_handle_q <= pend_handle_d;
    pend_arg_q <= pend_arg_d;
    res_q <= res_d;
  end

  // Sequencer: next state, memory port, subtractor operands and results.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    i_d = i_q;
    n_d = n_q;
    t_d = t_q;
    new_handle_d = new_handle_q;
    new_arg_d = new_arg_q;
    carry_d = carry_q;
    fix_d = fix_q;
    dec_done_d = dec_done_q;
    emit_d = emit_q;
    pend_valid_d = pend_valid_q;
    pend_handle_d = pend_handle_q;
    pend_arg_d = pend_arg_q;
    res_valid_d = 1'b0;
    res_d = '0;
    mem_we = 1'b0;
    mem_waddr = i_q[AW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = '0;
    alu_a = t_q;
    alu_b = mem_rdata.delta;
    dec_now = 1'b0;
    emit_ok = 1'b0;

    unique case (state_q)
      dltq_pkg::ST_IDLE: begin
        if (start) begin
          if (cmd_i.kind == dltq_pkg::KIND_INSERT) begin
            if (count_q == CW'(QUEUE_DEPTH)) begin
              res_valid_d = 1'b1;
              res_d.status = dltq_pkg::STATUS_REJECT;
              res_d.last = 1'b1;
            end else begin
              t_d = cmd_i.delay;
              new_handle_d = cmd_i.handle;
              new_arg_d = cmd_i.argument;
              i_d = '0;
              state_d = dltq_pkg::ST_INS_WALK;
            end
          end else if (count_q != '0) begin
            i_d = '0;
            n_d = '0;
            dec_done_d = 1'b0;
            emit_d = 1'b1;
            pend_valid_d = 1'b0;
            state_d = dltq_pkg::ST_TICK_SCAN;
          end
        end
      end

      // Subtract deltas until an entry lies beyond the new expiry time.
      dltq_pkg::ST_INS_WALK: begin
        alu_a = t_q;
        alu_b = mem_rdata.delta;
        mem_wdata = '{delta: t_q, handle: new_handle_q, argument: new_arg_q};
        if (i_q == count_q) begin
          mem_we = 1'b1;
          count_d = count_q + CW'(1);
          res_valid_d = 1'b1;
          res_d.status = dltq_pkg::STATUS_ACCEPT;
          res_d.last = 1'b1;
          state_d = dltq_pkg::ST_IDLE;
        end else if (!alu_res.borrow) begin
          t_d = alu_res.diff;
          i_d = i_next;
          mem_raddr = i_next[AW-1:0];
        end else begin
          mem_we = 1'b1;
          carry_d = mem_rdata;
          fix_d = 1'b1;
          i_d = i_next;
          mem_raddr = i_next[AW-1:0];
          state_d = dltq_pkg::ST_INS_SHIFT;
        end
      end

      // Ripple the displaced entries one place back; the first one loses t.
      dltq_pkg::ST_INS_SHIFT: begin
        alu_a = carry_q.delta;
        alu_b = t_q;
        mem_we = 1'b1;
        mem_wdata = carry_q;
        if (fix_q) begin
          mem_wdata.delta = alu_res.diff;
        end
        fix_d = 1'b0;
        if (i_q == count_q) begin
          count_d = count_q + CW'(1);
          res_valid_d = 1'b1;
          res_d.status = dltq_pkg::STATUS_ACCEPT;
          res_d.last = 1'b1;
          state_d = dltq_pkg::ST_IDLE;
        end else begin
          carry_d = mem_rdata;
          i_d = i_next;
          mem_raddr = i_next[AW-1:0];
        end
      end

      // Decrement the first positive delta and report the run of zeros.
      // A result is held back one entry so that its last flag is known.
      dltq_pkg::ST_TICK_SCAN: begin
        dec_now = !dec_done_q && (mem_rdata.delta != '0);
        alu_a = mem_rdata.delta;
        alu_b = {{(dltq_pkg::DELTA_W-1){1'b0}}, dec_now};
        mem_wdata.delta = alu_res.diff;
        mem_we = dec_now;
        dec_done_d = dec_done_q | dec_now;
        emit_ok = emit_q && alu_res.zero && (n_q < CW'(MaxEmit));
        if (emit_ok) begin
          if (pend_valid_q) begin
            res_valid_d = 1'b1;
            res_d.status = dltq_pkg::STATUS_EXPIRED;
            res_d.expired_handle = pend_handle_q;
            res_d.expired_argument = pend_arg_q;
          end
          pend_valid_d = 1'b1;
          pend_handle_d = mem_rdata.handle;
          pend_arg_d = mem_rdata.argument;
          n_d = n_q + CW'(1);
        end else if (emit_q) begin
          emit_d = 1'b0;
          pend_valid_d = 1'b0;
          if (pend_valid_q) begin
            res_valid_d = 1'b1;
            res_d.status = dltq_pkg::STATUS_EXPIRED;
            res_d.expired_handle = pend_handle_q;
            res_d.expired_argument = pend_arg_q;
            res_d.last = 1'b1;
          end
        end
        if ((i_next < count_q) && (!(dec_done_q | dec_now) || emit_ok)) begin
          i_d = i_next;
          mem_raddr = i_next[AW-1:0];
        end else begin
          state_d = dltq_pkg::ST_TICK_FLUSH;
        end
      end

      // Release a held result and, if survivors must move, set up the move to the front.
      dltq_pkg::ST_TICK_FLUSH: begin
        pend_valid_d = 1'b0;
        if (pend_valid_q) begin
          res_valid_d = 1'b1;
          res_d.status = dltq_pkg::STATUS_EXPIRED;
          res_d.expired_handle = pend_handle_q;
          res_d.expired_argument = pend_arg_q;
          res_d.last = 1'b1;
        end
        if (n_q == '0) begin
          state_d = dltq_pkg::ST_IDLE;
        end else if (n_q == count_q) begin
          count_d = '0;
          state_d = dltq_pkg::ST_IDLE;
        end else begin
          i_d = n_q;
          mem_raddr = n_q[AW-1:0];
          state_d = dltq_pkg::ST_TICK_COMPACT;
        end
      end

      // Move each surviving entry forward by the number removed.
      dltq_pkg::ST_TICK_COMPACT: begin
        mem_we = 1'b1;
        mem_waddr = AW'(i_q - n_q);
        mem_wdata = mem_rdata;
        if (i_next < count_q) begin
          i_d = i_next;
          mem_raddr = i_next[AW-1:0];
        end else begin
          count_d = count_q - n_q;
          state_d = dltq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = dltq_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != dltq_pkg::ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o = res_q;

`ifndef SYNTHESIS
  // A result without last is always followed by more from the same item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy)
    else $error("non-final result while sequencer idle");

  // Insert results are always single and final.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.status != dltq_pkg::STATUS_EXPIRED) |-> res_o.last)
    else $error("insert result without last");

  // The list never holds more entries than the memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond depth");

  // An insert into a full list is rejected in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i.kind == dltq_pkg::KIND_INSERT) &&
    (count_q == CW'(QUEUE_DEPTH))
    |=> res_valid_o && (res_o.status == dltq_pkg::STATUS_REJECT))
    else $error("full-list insert not rejected");
`endif

endmodule

`default_nettype wire

### hdl/dltq_alu.sv
`default_nettype none

module dltq_alu (
  input  wire logic [dltq_pkg::DELTA_W-1:0] a_i,
  input  wire logic [dltq_pkg::DELTA_W-1:0] b_i,
  output dltq_pkg::alu_res_t                res_o
);

  logic [dltq_pkg::DELTA_W:0] full;

  // One subtractor serves the walk, the delta fix-up and the tick decrement.
  assign full = {1'b0, a_i} - {1'b0, b_i};
  assign res_o = '{diff:   full[dltq_pkg::DELTA_W-1:0],
                   borrow: full[dltq_pkg::DELTA_W],
                   zero:   (full[dltq_pkg::DELTA_W-1:0] == '0)};

endmodule

`default_nettype wire

### hdl/dltq_mem.sv
`default_nettype none

module dltq_mem #(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire dltq_pkg::entry_t wdata_i,
  input  wire logic [AW-1:0]   raddr_i,
  output dltq_pkg::entry_t     rdata_o
);

  dltq_pkg::entry_t mem_q [DEPTH];
  dltq_pkg::entry_t rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Single read port with registered data.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int QUEUE_DEPTH = 16;
  localparam int DELTA_W = dltq_pkg::DELTA_W;
  localparam int HANDLE_W = dltq_pkg::HANDLE_W;
  localparam int ARG_W = dltq_pkg::ARG_W;
  localparam int RANDOM_ITEMS = 450;
  localparam int CALM_ITEMS = 60;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;
  localparam int MAX_PRINTS = 30;
  localparam int FAR_TICKS = 200;

  // One row of the directed stimulus table.
  typedef struct {
    dltq_pkg::in_item_t  cmd;
    bit                  typed;
    int                  nexp;
    dltq_pkg::res_item_t exp;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  dltq_pkg::in_item_t  cmd_i;
  logic                res_valid_o;
  dltq_pkg::res_item_t res_o;

  // Side information travelling with the item on the command port.
  logic                cur_typed;
  int                  cur_nexp;
  dltq_pkg::res_item_t cur_exp;

  // Shadow copy of the timer list.
  logic [DELTA_W-1:0]  list_delta [QUEUE_DEPTH];
  logic [HANDLE_W-1:0] list_handle [QUEUE_DEPTH];
  logic [ARG_W-1:0]    list_arg [QUEUE_DEPTH];
  int                  list_len;
  int                  list_peak;

  dltq_pkg::res_item_t step_results [$];
  dltq_pkg::res_item_t pending_results [$];
  stim_row_t           directed_rows [$];

  int errors;
  int quiet_cycles;
  int n_items;
  int n_results;
  int n_expired;
  int n_accepted;
  int n_rejected;
  int n_sent;
  bit idle_on;

  delta_list_timer_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (errors < MAX_PRINTS) begin
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    end
    errors++;
  endtask

  // Applies one item to the shadow list and leaves the results it causes in
  // step_results.
  task automatic timer_list_step(input dltq_pkg::in_item_t it);
    int idx;
    int n;
    int j;
    logic [DELTA_W-1:0] rest;
    step_results.delete();
    if (it.kind == dltq_pkg::KIND_INSERT) begin
      if (list_len >= QUEUE_DEPTH) begin
        step_results.push_back('{dltq_pkg::STATUS_REJECT, '0, '0, 1'b1});
      end else begin
        // Walk past every entry that expires no later than the new one.
        rest = it.delay;
        idx = 0;
        while (idx < list_len && list_delta[idx] <= rest) begin
          rest -= list_delta[idx];
          idx++;
        end
        if (idx < list_len) begin
          list_delta[idx] -= rest;
        end
        for (j = list_len; j > idx; j--) begin
          list_delta[j] = list_delta[j-1];
          list_handle[j] = list_handle[j-1];
          list_arg[j] = list_arg[j-1];
        end
        list_delta[idx] = rest;
        list_handle[idx] = it.handle;
        list_arg[idx] = it.argument;
        list_len++;
        if (list_len > list_peak) begin
          list_peak = list_len;
        end
        step_results.push_back('{dltq_pkg::STATUS_ACCEPT, '0, '0, 1'b1});
      end
    end else if (list_len != 0) begin
      // Count down the first entry still pending.
      idx = 0;
      while (idx < list_len && list_delta[idx] == 0) begin
        idx++;
      end
      if (idx < list_len) begin
        list_delta[idx] -= 1'b1;
      end
      // Report and drop the leading run of expired entries.
      n = 0;
      while (n < list_len && n < dltq_pkg::MAX_RESULTS && list_delta[n] == 0) begin
        n++;
      end
      for (j = 0; j < n; j++) begin
        step_results.push_back('{dltq_pkg::STATUS_EXPIRED, list_handle[j], list_arg[j],
                                 (j == n - 1)});
      end
      for (j = n; j < list_len; j++) begin
        list_delta[j-n] = list_delta[j];
        list_handle[j-n] = list_handle[j];
        list_arg[j-n] = list_arg[j];
      end
      list_len -= n;
    end
  endtask

  // Number of pending entries that lie far in the future.
  function automatic int far_count();
    int sum;
    int cnt;
    sum = 0;
    cnt = 0;
    for (int k = 0; k < list_len; k++) begin
      sum += list_delta[k];
      if (sum > FAR_TICKS) begin
        cnt++;
      end
    end
    return cnt;
  endfunction

  function automatic dltq_pkg::in_item_t make_item(input logic kind,
                                                   input logic [DELTA_W-1:0] delay);
    dltq_pkg::in_item_t it;
    it.kind = kind;
    it.delay = delay;
    it.handle = HANDLE_W'($urandom);
    it.argument = $urandom;
    return it;
  endfunction

  // Mostly near expiries, now and then one anywhere in the delay range.
  function automatic logic [DELTA_W-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return DELTA_W'($urandom_range(0, 6));
    end else if (r < 90 || far_count() >= 2) begin
      return DELTA_W'($urandom_range(0, 24));
    end else if (r < 93) begin
      return '1;
    end
    return DELTA_W'($urandom);
  endfunction

  function automatic void add_row(input logic kind, input logic [DELTA_W-1:0] delay,
                                  input logic [HANDLE_W-1:0] handle,
                                  input logic [ARG_W-1:0] argument, input bit typed,
                                  input int nexp, input dltq_pkg::res_item_t exp);
    stim_row_t row;
    row.cmd = '{kind, delay, handle, argument};
    row.typed = typed;
    row.nexp = nexp;
    row.exp = exp;
    directed_rows.push_back(row);
  endfunction

  // Offers one item, possibly after an idle burst, and waits until taken.
  task automatic send_item(input dltq_pkg::in_item_t it, input bit typed, input int nexp,
                           input dltq_pkg::res_item_t exp);
    int gap;
    if (idle_on && n_sent < RANDOM_ITEMS + 25 - CALM_ITEMS && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      start <= 1'b0;
      cmd_i <= make_item(1'($urandom), DELTA_W'($urandom));
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= it;
    cur_typed <= typed;
    cur_nexp <= nexp;
    cur_exp <= exp;
    do @(posedge clk_i); while (busy);
    n_sent++;
  endtask

  task automatic send_checked(input dltq_pkg::in_item_t it);
    send_item(it, 1'b0, 0, '0);
  endtask

  // Accepts items into the shadow list and checks every result strobe.
  always @(posedge clk_i) begin : monitor
    dltq_pkg::res_item_t want;
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (start && !busy) begin
        timer_list_step(cmd_i);
        n_items++;
        moved = 1'b1;
        if (cur_typed) begin
          for (int k = 0; k < cur_nexp; k++) begin
            pending_results.push_back(cur_exp);
          end
        end else begin
          foreach (step_results[k]) begin
            pending_results.push_back(step_results[k]);
          end
        end
      end
      if (res_valid_o) begin
        n_results++;
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          flag_mismatch("unexpected result", 64'(res_o), 64'd0);
        end else begin
          want = pending_results.pop_front();
          case (want.status)
            dltq_pkg::STATUS_EXPIRED: n_expired++;
            dltq_pkg::STATUS_ACCEPT:  n_accepted++;
            default:                  n_rejected++;
          endcase
          if (res_o.status !== want.status) begin
            flag_mismatch("status", 64'(res_o.status), 64'(want.status));
          end
          if (res_o.expired_handle !== want.expired_handle) begin
            flag_mismatch("expired_handle", 64'(res_o.expired_handle),
                          64'(want.expired_handle));
          end
          if (res_o.expired_argument !== want.expired_argument) begin
            flag_mismatch("expired_argument", 64'(res_o.expired_argument),
                          64'(want.expired_argument));
          end
          if (res_o.last !== want.last) begin
            flag_mismatch("last", 64'(res_o.last), 64'(want.last));
          end
        end
      end
      // Watchdog on cycles that move nothing.
      if (moved) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no progress for %0d cycles", $realtime, QUIET_LIMIT);
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  // Stimulus.
  initial begin : driver
    int mode;
    int len;
    int guard;
    dltq_pkg::res_item_t ok;
    dltq_pkg::res_item_t full;
    rst_ni <= 1'b0;
    start <= 1'b0;
    cmd_i <= '0;
    cur_typed <= 1'b0;
    cur_nexp <= 0;
    cur_exp <= '0;
    list_len = 0;
    list_peak = 0;
    errors = 0;
    quiet_cycles = 0;
    n_items = 0;
    n_results = 0;
    n_expired = 0;
    n_accepted = 0;
    n_rejected = 0;
    n_sent = 0;
    idle_on = 1'b1;
    ok = '{dltq_pkg::STATUS_ACCEPT, '0, '0, 1'b1};
    full = '{dltq_pkg::STATUS_REJECT, '0, '0, 1'b1};

    // Directed table: empty list, extremes, equal expiries, overflow.
    add_row(dltq_pkg::KIND_TICK, 16'h0000, 8'h00, 32'h0, 1'b1, 0, '0);
    add_row(dltq_pkg::KIND_INSERT, 16'h0000, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1, ok);
    add_row(dltq_pkg::KIND_TICK, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1,
            '{dltq_pkg::STATUS_EXPIRED, 8'hFF, 32'hFFFF_FFFF, 1'b1});
    add_row(dltq_pkg::KIND_INSERT, 16'hFFFF, 8'h00, 32'h0, 1'b1, 1, ok);
    add_row(dltq_pkg::KIND_INSERT, 16'd3, 8'h11, 32'hA5A5_A5A5, 1'b1, 1, ok);
    add_row(dltq_pkg::KIND_INSERT, 16'd3, 8'h22, 32'h5A5A_5A5A, 1'b1, 1, ok);
    add_row(dltq_pkg::KIND_INSERT, 16'd1, 8'h33, 32'h0000_0001, 1'b1, 1, ok);
    add_row(dltq_pkg::KIND_INSERT, 16'd0, 8'h44, 32'h8000_0000, 1'b1, 1, ok);
    add_row(dltq_pkg::KIND_TICK, 16'd0, 8'h00, 32'h0, 1'b0, 0, '0);
    add_row(dltq_pkg::KIND_TICK, 16'd0, 8'h00, 32'h0, 1'b0, 0, '0);
    for (int k = 0; k < 13; k++) begin
      add_row(dltq_pkg::KIND_INSERT, 16'd0, 8'(8'h80 + k), 32'(32'h1234_5600 + k),
              1'b1, 1, ok);
    end
    add_row(dltq_pkg::KIND_INSERT, 16'd7, 8'hEE, 32'hDEAD_BEEF, 1'b1, 1, full);
    add_row(dltq_pkg::KIND_TICK, 16'd0, 8'h00, 32'h0, 1'b0, 0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].cmd, directed_rows[r].typed, directed_rows[r].nexp,
                directed_rows[r].exp);
    end

    // Random segments of differing character.
    while (n_sent < RANDOM_ITEMS + directed_rows.size()) begin
      mode = $urandom_range(0, 9);
      idle_on = ($urandom_range(0, 9) < 7);
      if (mode <= 5) begin
        // Mixed inserts and ticks.
        len = $urandom_range(10, 30);
        repeat (len) begin
          if ($urandom_range(0, 99) < 55) begin
            send_checked(make_item(dltq_pkg::KIND_INSERT, pick_delay()));
          end else begin
            send_checked(make_item(dltq_pkg::KIND_TICK, DELTA_W'($urandom)));
          end
        end
      end else if (mode <= 7) begin
        // Fill the list with near expiries, overrun it, then drain it.
        guard = 0;
        while (list_len < QUEUE_DEPTH && guard < QUEUE_DEPTH + 2) begin
          send_checked(make_item(dltq_pkg::KIND_INSERT, DELTA_W'($urandom_range(0, 4))));
          guard++;
        end
        repeat ($urandom_range(1, 2)) begin
          send_checked(make_item(dltq_pkg::KIND_INSERT, DELTA_W'($urandom)));
        end
        guard = 0;
        while (list_len != 0 && guard < 12) begin
          send_checked(make_item(dltq_pkg::KIND_TICK, DELTA_W'($urandom)));
          guard++;
        end
      end else if (mode == 8) begin
        // A run of ticks.
        repeat ($urandom_range(5, 15)) begin
          send_checked(make_item(dltq_pkg::KIND_TICK, DELTA_W'($urandom)));
        end
      end else begin
        // Noise: any kind, delays across the whole range where room allows.
        repeat ($urandom_range(4, 12)) begin
          send_checked(make_item(1'($urandom),
                                 (far_count() < 2) ? DELTA_W'($urandom) : pick_delay()));
        end
      end
    end
    start <= 1'b0;

    // Let the last results drain out.
    while (pending_results.size() != 0 || busy) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      flag_mismatch("results never delivered", 64'(pending_results.size()), 64'd0);
    end

    $display("Covered %0d items (%0d from the directed table) and %0d results.",
             n_items, directed_rows.size(), n_results);
    $display("Expiries %0d, inserts taken %0d, inserts refused %0d, peak occupancy %0d.",
             n_expired, n_accepted, n_rejected, list_peak);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
